// File: hw/rtl/lprt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lprt_pkg;

    localparam int CORDIC_ITERS = 24;
    localparam int ANG_W        = 34;
    localparam int PRE_SHIFT    = 16;
    localparam int GAIN_Q16     = 107922;
    localparam int PERIOD_BITS  = 20;
    localparam int INTEN_BITS   = 8;
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 20'd100000;

    localparam int ELEV_SCALE  = 3600;
    localparam int ELEV_OFFSET = 248;
    localparam int ELEV_SPAN   = 268;
    localparam int RING_DIV    = 536;
    localparam int RING_RECIP  = 62602;
    localparam int RECIP_SHIFT = 25;
    localparam int RECIP_BITS  = 16;

    localparam int A_W = 48;
    localparam int N_W = 56;
    localparam int Q_W = 24;

    localparam logic [31:0] ATAN_TURN32 [0:CORDIC_ITERS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage

`default_nettype wire

// File: hw/rtl/lidar_point_ring_and_time_tagger_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Each accepted word passes the input register, both CORDICs and the tail.
// Throughput is one word per cycle when not stalled: two unrolled 24-stage
// CORDIC pipelines and a four-stage ring and time tail, all on one common enable.
// The pipeline holds its contents while the output word waits to be taken.
// Synchronous active-low reset clears the valid bits, sets the sweep period
// to 100000 us and clears the stored sweep start azimuth.

module lidar_point_ring_and_time_tagger_core import lprt_pkg::*; #(
    parameter int ANGLE_BITS = 16,
    parameter int COORD_BITS = 19,
    parameter int RING_COUNT = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [PERIOD_BITS-1:0]          i_cfg_wdata,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_first_of_sweep,
    input  wire logic [COORD_BITS-1:0]           i_x_mm,
    input  wire logic [COORD_BITS-1:0]           i_y_mm,
    input  wire logic [COORD_BITS-1:0]           i_z_mm,
    input  wire logic [INTEN_BITS-1:0]           i_intensity,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [COORD_BITS-1:0]                o_out_x_mm,
    output logic [COORD_BITS-1:0]                o_out_y_mm,
    output logic [COORD_BITS-1:0]                o_out_z_mm,
    output logic [INTEN_BITS-1:0]                o_out_intensity,
    output logic [$clog2(RING_COUNT)-1:0]        o_ring_index,
    output logic [PERIOD_BITS-1:0]               o_time_offset_us
);

    localparam int W       = COORD_BITS + 20;
    localparam int RING_B  = $clog2(RING_COUNT);
    localparam int SH      = 32 - ANGLE_BITS;
    localparam int QB      = $clog2(RING_COUNT * RING_DIV);
    localparam int T_W     = ANGLE_BITS + PERIOD_BITS;
    localparam int NITER   = CORDIC_ITERS;

    typedef struct packed {
        logic                  first;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
        logic [INTEN_BITS-1:0] inten;
        logic                  nz;
    } t_ameta;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
        logic [INTEN_BITS-1:0] inten;
        logic                  ok;
        logic [ANGLE_BITS-1:0] rel;
    } t_emeta;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
        logic [INTEN_BITS-1:0] inten;
        logic                  ok;
    } t_tmeta;

    logic en;
    assign en = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    logic [PERIOD_BITS-1:0] r_period;
    logic [ANGLE_BITS-1:0]  r_sweep_az;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_wdata;
        end
    end

    logic                     r_av  [0:NITER];
    t_ameta                   r_am  [0:NITER];
    logic signed [W-1:0]      r_ax  [0:NITER];
    logic signed [W-1:0]      r_ay  [0:NITER];
    logic signed [ANG_W-1:0]  r_aa  [0:NITER];
    logic signed [W-1:0]      r_aez [0:NITER];

    logic signed [W-1:0] c_xe, c_ye, c_ze, c_xs, c_ys, c_ez;
    logic                c_neg;

    assign c_xe  = W'($signed(i_x_mm));
    assign c_ye  = W'($signed(i_y_mm));
    assign c_ze  = W'($signed(i_z_mm));
    assign c_xs  = c_xe <<< PRE_SHIFT;
    assign c_ys  = c_ye <<< PRE_SHIFT;
    assign c_ez  = c_ze * $signed(W'(GAIN_Q16));
    assign c_neg = i_x_mm[COORD_BITS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av[0] <= 1'b0;
        end else if (en) begin
            r_av[0] <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_am[0].first <= i_first_of_sweep;
            r_am[0].x     <= i_x_mm;
            r_am[0].y     <= i_y_mm;
            r_am[0].z     <= i_z_mm;
            r_am[0].inten <= i_intensity;
            r_am[0].nz    <= (i_x_mm != '0) || (i_y_mm != '0);
            r_ax[0]       <= c_neg ? -c_xs : c_xs;
            r_ay[0]       <= c_neg ? -c_ys : c_ys;
            r_aa[0]       <= c_neg ? (ANG_W'(1) <<< 31) : '0;
            r_aez[0]      <= c_ez;
        end
    end

    for (genvar gi = 0; gi < NITER; gi++) begin : g_az
        logic signed [W-1:0]     c_dx, c_dy;
        logic signed [ANG_W-1:0] c_at;
        logic                    c_down;

        assign c_dx   = r_ay[gi] >>> gi;
        assign c_dy   = r_ax[gi] >>> gi;
        assign c_at   = $signed(ANG_W'(ATAN_TURN32[gi]));
        assign c_down = r_ay[gi][W-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_av[gi+1] <= 1'b0;
            end else if (en) begin
                r_av[gi+1] <= r_av[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_am[gi+1]  <= r_am[gi];
                r_aez[gi+1] <= r_aez[gi];
                r_ax[gi+1]  <= c_down ? r_ax[gi] - c_dx : r_ax[gi] + c_dx;
                r_ay[gi+1]  <= c_down ? r_ay[gi] + c_dy : r_ay[gi] - c_dy;
                r_aa[gi+1]  <= c_down ? r_aa[gi] - c_at : r_aa[gi] + c_at;
            end
        end
    end

    logic [31:0]           c_a32;
    logic [ANGLE_BITS-1:0] c_az, c_ref, c_rel;

    assign c_a32 = r_aa[NITER][31:0] + (32'd1 << (SH - 1));
    assign c_az  = r_am[NITER].nz ? c_a32[31:SH] : '0;
    assign c_ref = r_am[NITER].first ? c_az : r_sweep_az;
    assign c_rel = c_ref - c_az;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_az <= '0;
        end else if (en && r_av[NITER] && r_am[NITER].first) begin
            r_sweep_az <= c_az;
        end
    end

    logic                     r_ev [0:NITER];
    t_emeta                   r_em [0:NITER];
    logic signed [W-1:0]      r_ex [0:NITER];
    logic signed [W-1:0]      r_ey [0:NITER];
    logic signed [ANG_W-1:0]  r_ea [0:NITER];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev[0] <= 1'b0;
        end else if (en) begin
            r_ev[0] <= r_av[NITER];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_em[0].x     <= r_am[NITER].x;
            r_em[0].y     <= r_am[NITER].y;
            r_em[0].z     <= r_am[NITER].z;
            r_em[0].inten <= r_am[NITER].inten;
            r_em[0].ok    <= r_am[NITER].nz && (r_ax[NITER] > 0);
            r_em[0].rel   <= c_rel;
            r_ex[0]       <= r_ax[NITER];
            r_ey[0]       <= r_aez[NITER];
            r_ea[0]       <= '0;
        end
    end

    for (genvar gi = 0; gi < NITER; gi++) begin : g_el
        logic signed [W-1:0]     c_dx, c_dy;
        logic signed [ANG_W-1:0] c_at;
        logic                    c_down;

        assign c_dx   = r_ey[gi] >>> gi;
        assign c_dy   = r_ex[gi] >>> gi;
        assign c_at   = $signed(ANG_W'(ATAN_TURN32[gi]));
        assign c_down = r_ey[gi][W-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ev[gi+1] <= 1'b0;
            end else if (en) begin
                r_ev[gi+1] <= r_ev[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_em[gi+1] <= r_em[gi];
                r_ex[gi+1] <= c_down ? r_ex[gi] - c_dx : r_ex[gi] + c_dx;
                r_ey[gi+1] <= c_down ? r_ey[gi] + c_dy : r_ey[gi] - c_dy;
                r_ea[gi+1] <= c_down ? r_ea[gi] - c_at : r_ea[gi] + c_at;
            end
        end
    end

    logic                  r_r1_v, r_r2_v, r_r3_v;
    t_tmeta                r_r1_m, r_r2_m, r_r3_m;
    logic signed [A_W-1:0] r_r1_a;
    logic [T_W-1:0]        r_r1_tp;
    logic [Q_W-1:0]        r_r2_q;
    logic [PERIOD_BITS-1:0] r_r2_t, r_r3_t;
    logic                  r_r3_sat;
    logic [QB+RECIP_BITS-1:0] r_r3_prod;

    logic signed [A_W-1:0] c_a;
    logic signed [N_W-1:0] c_n;
    logic [T_W-1:0]        c_tr;
    logic [RING_B-1:0]     c_ring;

    assign c_a  = A_W'(r_ea[NITER]) * $signed(A_W'(ELEV_SCALE))
                + ($signed(A_W'(ELEV_OFFSET)) <<< 32);
    assign c_n  = N_W'(r_r1_a) * $signed(N_W'(2 * (RING_COUNT - 1)))
                + ($signed(N_W'(ELEV_SPAN)) <<< 32);
    assign c_tr = r_r1_tp + (T_W'(1) << (ANGLE_BITS - 1));

    always_comb begin
        priority if (!r_r3_m.ok) begin
            c_ring = '0;
        end else if (r_r3_sat) begin
            c_ring = RING_B'(RING_COUNT - 1);
        end else begin
            c_ring = r_r3_prod[RECIP_SHIFT +: RING_B];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1_v      <= 1'b0;
            r_r2_v      <= 1'b0;
            r_r3_v      <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (en) begin
            r_r1_v      <= r_ev[NITER];
            r_r2_v      <= r_r1_v;
            r_r3_v      <= r_r2_v;
            o_out_valid <= r_r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r1_m.x     <= r_em[NITER].x;
            r_r1_m.y     <= r_em[NITER].y;
            r_r1_m.z     <= r_em[NITER].z;
            r_r1_m.inten <= r_em[NITER].inten;
            r_r1_m.ok    <= r_em[NITER].ok;
            r_r1_a       <= c_a;
            r_r1_tp      <= T_W'(r_em[NITER].rel) * T_W'(r_period);

            r_r2_m.x     <= r_r1_m.x;
            r_r2_m.y     <= r_r1_m.y;
            r_r2_m.z     <= r_r1_m.z;
            r_r2_m.inten <= r_r1_m.inten;
            r_r2_m.ok    <= r_r1_m.ok && !r_r1_a[A_W-1];
            r_r2_q       <= c_n[N_W-1:32];
            r_r2_t       <= c_tr[ANGLE_BITS +: PERIOD_BITS];

            r_r3_m       <= r_r2_m;
            r_r3_sat     <= r_r2_q >= Q_W'(RING_COUNT * RING_DIV);
            r_r3_prod    <= (QB+RECIP_BITS)'(r_r2_q[QB-1:0])
                          * (QB+RECIP_BITS)'(RING_RECIP);
            r_r3_t       <= r_r2_t;

            o_out_x_mm       <= r_r3_m.x;
            o_out_y_mm       <= r_r3_m.y;
            o_out_z_mm       <= r_r3_m.z;
            o_out_intensity  <= r_r3_m.inten;
            o_ring_index     <= c_ring;
            o_time_offset_us <= r_r3_t;
        end
    end

endmodule

`default_nettype wire

// File: tb/point_tag_checker.sv
`timescale 1ns / 1ps

module point_tag_checker import lprt_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [PERIOD_BITS-1:0] i_cfg_wdata,
    input  wire logic                   i_in_valid,
    input  wire logic                   i_in_ready,
    input  wire logic                   i_first_of_sweep,
    input  wire logic [18:0]            i_x_mm,
    input  wire logic [18:0]            i_y_mm,
    input  wire logic [18:0]            i_z_mm,
    input  wire logic [INTEN_BITS-1:0]  i_intensity,
    input  wire logic                   i_out_valid,
    input  wire logic                   i_out_ready,
    input  wire logic [18:0]            i_out_x_mm,
    input  wire logic [18:0]            i_out_y_mm,
    input  wire logic [18:0]            i_out_z_mm,
    input  wire logic [INTEN_BITS-1:0]  i_out_intensity,
    input  wire logic [5:0]             i_ring_index,
    input  wire logic [PERIOD_BITS-1:0] i_time_offset_us,
    output int                          o_fail_count,
    output int                          o_pending
);

    typedef struct packed {
        logic [18:0]            x_mm;
        logic [18:0]            y_mm;
        logic [18:0]            z_mm;
        logic [INTEN_BITS-1:0]  intensity;
        logic [5:0]             ring;
        logic [PERIOD_BITS-1:0] t_us;
    } tagged_point_t;

    tagged_point_t          tag_q[$];
    logic [PERIOD_BITS-1:0] period_us;
    logic [15:0]            start_az;

    initial o_fail_count = 0;
    assign o_pending = tag_q.size();

    // Vectoring CORDIC with 2^32 units per turn; drives y toward zero.
    function automatic void cordic_vec(inout longint x, inout longint y, inout longint a);
        longint dx;
        longint dy;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0) begin
                x = x - dx;
                y = y + dy;
                a = a - longint'(ATAN_TURN32[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                a = a + longint'(ATAN_TURN32[i]);
            end
        end
    endfunction

    function automatic tagged_point_t tag_point(logic first, logic [18:0] xr, logic [18:0] yr,
                                                logic [18:0] zr, logic [INTEN_BITS-1:0] inten);
        tagged_point_t r;
        longint x;
        longint y;
        longint z;
        longint cx;
        longint cy;
        longint ca;
        longint ez;
        longint ea;
        longint num;
        longint den;
        longint rq;
        longint a32;
        logic [15:0] az;
        logic [15:0] rel;
        logic [5:0] ring;
        x = longint'($signed(xr));
        y = longint'($signed(yr));
        z = longint'($signed(zr));
        az = '0;
        ring = '0;
        if (x != 0 || y != 0) begin
            cx = x * 65536;
            cy = y * 65536;
            ca = 0;
            ea = 0;
            if (cx < 0) begin
                cx = -cx;
                cy = -cy;
                ca = longint'(1) << 31;
            end
            cordic_vec(cx, cy, ca);
            a32 = ca & 64'hFFFF_FFFF;
            az = 16'((a32 + 32768) >> 16);
            ez = z * GAIN_Q16;
            if (cx > 0) begin
                cordic_vec(cx, ez, ea);
                num = (ea * ELEV_SCALE + longint'(ELEV_OFFSET) * (longint'(1) << 32)) * 63;
                den = longint'(ELEV_SPAN) * (longint'(1) << 32);
                if (num >= 0) begin
                    rq = (2 * num + den) / (2 * den);
                    ring = (rq > 63) ? 6'd63 : 6'(rq);
                end
            end
        end
        if (first) start_az = az;
        rel = start_az - az;
        r.x_mm = xr;
        r.y_mm = yr;
        r.z_mm = zr;
        r.intensity = inten;
        r.ring = ring;
        r.t_us = PERIOD_BITS'((longint'(rel) * longint'(period_us) + 32768) >> 16);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        tagged_point_t e;
        if (!i_rst_n) begin
            period_us <= PERIOD_RESET;
            start_az = '0;
            tag_q.delete();
        end else begin
            if (i_cfg_we) period_us <= i_cfg_wdata;
            if (i_in_valid && i_in_ready)
                tag_q.push_back(tag_point(i_first_of_sweep, i_x_mm, i_y_mm, i_z_mm,
                                          i_intensity));
            if (i_out_valid && i_out_ready) begin
                if (tag_q.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    e = tag_q.pop_front();
                    if (i_out_x_mm != e.x_mm) report_mismatch("x", i_out_x_mm, e.x_mm);
                    if (i_out_y_mm != e.y_mm) report_mismatch("y", i_out_y_mm, e.y_mm);
                    if (i_out_z_mm != e.z_mm) report_mismatch("z", i_out_z_mm, e.z_mm);
                    if (i_out_intensity != e.intensity)
                        report_mismatch("intensity", i_out_intensity, e.intensity);
                    if (i_ring_index != e.ring) report_mismatch("ring", i_ring_index, e.ring);
                    if (i_time_offset_us != e.t_us)
                        report_mismatch("time offset", i_time_offset_us, e.t_us);
                end
            end
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import lprt_pkg::*;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [PERIOD_BITS-1:0] i_cfg_wdata = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic                   i_first_of_sweep = 1'b0;
    logic [18:0]            i_x_mm = '0;
    logic [18:0]            i_y_mm = '0;
    logic [18:0]            i_z_mm = '0;
    logic [INTEN_BITS-1:0]  i_intensity = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [18:0]            o_out_x_mm;
    logic [18:0]            o_out_y_mm;
    logic [18:0]            o_out_z_mm;
    logic [INTEN_BITS-1:0]  o_out_intensity;
    logic [5:0]             o_ring_index;
    logic [PERIOD_BITS-1:0] o_time_offset_us;
    int                     fail_count;
    int                     pending;
    int                     cycles = 0;
    int                     stall_left = 0;
    bit                     calm = 1'b0;

    always #1 i_clk = ~i_clk;

    lidar_point_ring_and_time_tagger_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_first_of_sweep(i_first_of_sweep), .i_x_mm(i_x_mm), .i_y_mm(i_y_mm),
        .i_z_mm(i_z_mm), .i_intensity(i_intensity),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_out_x_mm(o_out_x_mm), .o_out_y_mm(o_out_y_mm), .o_out_z_mm(o_out_z_mm),
        .o_out_intensity(o_out_intensity), .o_ring_index(o_ring_index),
        .o_time_offset_us(o_time_offset_us)
    );

    point_tag_checker checker_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_first_of_sweep(i_first_of_sweep), .i_x_mm(i_x_mm), .i_y_mm(i_y_mm),
        .i_z_mm(i_z_mm), .i_intensity(i_intensity),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_out_x_mm(o_out_x_mm), .i_out_y_mm(o_out_y_mm), .i_out_z_mm(o_out_z_mm),
        .i_out_intensity(o_out_intensity), .i_ring_index(o_ring_index),
        .i_time_offset_us(o_time_offset_us),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 6) == 0) begin
            stall_left <= $urandom_range(0, 10);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic send_point(logic first, logic [18:0] x, logic [18:0] y, logic [18:0] z,
                              logic [INTEN_BITS-1:0] inten);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_first_of_sweep <= first;
        i_x_mm <= x;
        i_y_mm <= y;
        i_z_mm <= z;
        i_intensity <= inten;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic set_period(logic [PERIOD_BITS-1:0] p);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= p;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [18:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 19'($urandom_range(0, 2000)) - 19'd1000;
            1: return $urandom_range(0, 1) ? 19'h3FFFF : 19'h40000;
            2: return '0;
            default: return 19'($urandom);
        endcase
    endfunction

    task automatic run_sweeps(int n);
        logic [18:0] x;
        logic [18:0] y;
        for (int i = 0; i < n; i++) begin
            x = pick_coord();
            y = pick_coord();
            if ($urandom_range(0, 9) == 0) x = '0;
            send_point($urandom_range(0, 15) == 0, x, y, pick_coord(), 8'($urandom));
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Before any sweep start the reference azimuth is zero.
        send_point(1'b0, 19'd1000, 19'd1000, 19'd0, 8'd0);
        send_point(1'b0, 19'd0, 19'd0, 19'd500, 8'd255);
        send_point(1'b1, 19'd0, 19'd0, 19'h40000, 8'd1);
        send_point(1'b0, 19'h3FFFF, 19'd0, 19'd0, 8'd2);
        send_point(1'b0, 19'h40000, 19'd0, 19'd0, 8'd3);
        send_point(1'b0, 19'h40000, 19'h40000, 19'h40000, 8'd4);
        send_point(1'b0, 19'h3FFFF, 19'h3FFFF, 19'h3FFFF, 8'd5);
        send_point(1'b1, 19'h7FFFF, 19'd1, 19'd0, 8'd6);
        send_point(1'b0, 19'h7FFFF, 19'h7FFFF, 19'd1, 8'd7);
        send_point(1'b0, 19'd0, 19'h3FFFF, 19'h40000, 8'd8);
        send_point(1'b0, 19'd0, 19'h40000, 19'h3FFFF, 8'd9);
        send_point(1'b0, 19'd1, 19'd0, 19'h3FFFF, 8'd10);
        send_point(1'b0, 19'd1, 19'd0, 19'h40000, 8'd11);
        send_point(1'b1, 19'd100, 19'h7FFFF, 19'h7FF00, 8'd12);
        send_point(1'b0, 19'd100, 19'd1, 19'd200, 8'd13);
        run_sweeps(130);

        set_period(20'd1);
        run_sweeps(120);
        set_period(20'hFFFFF);
        send_point(1'b1, 19'd1000, 19'd1, 19'd0, 8'd20);
        send_point(1'b0, 19'd1000, 19'h7FFFF, 19'd0, 8'd21);
        run_sweeps(120);
        set_period(20'd0);
        run_sweeps(100);
        set_period(20'($urandom_range(1, 1000000)));
        run_sweeps(80);
        calm = 1'b1;
        run_sweeps(100);
        set_period(20'd100000);
        run_sweeps(60);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
